@@ rtl/swmm_pkg.sv @@
// shared constants and types for the sliding window min/max filter
package swmm_pkg;

	// parameter defaults
	localparam int DEF_MAX_RADIUS  = 15;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_MAX_COLUMN  = 4096;

	// configuration register file
	localparam int RADIUS_BITS    = 4;
	localparam int CFG_DATA_BITS  = RADIUS_BITS;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIND_MIN = 2'd1;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET   = 4'd1;
	localparam logic                   FIND_MIN_RESET = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXP_CK,
		ST_POP_CK,
		ST_PUSH,
		ST_EMIT_TEST
	} swmm_state_t;

endpackage

@@ rtl/sliding_window_min_max_filter_top.sv @@
// sliding window min/max filter: deque kept in a one-read one-write memory
//
// Filters a stream of columns with a centered 1-D minimum (find_min = 1) or
// maximum (find_min = 0) over 2*radius+1 samples, the window clipped to the
// column. Candidates live in a monotonic deque of value/position pairs held in
// a synchronous memory of 2*MAX_RADIUS+2 entries; on a tie the older entry is
// dropped. Each input beat gives the result for the position radius back, and
// the beat with column_end set flushes every pending result of the column;
// last_of_run marks the final result beat caused by one input beat, and
// column_done the column's last position. A radius above MAX_RADIUS acts as
// MAX_RADIUS. Any write to radius or find_min also restarts the column, so
// write only while the block is idle. Reset clears the deque pointers at once,
// there is no clearing pass. Sequence: one input beat is taken in IDLE, then
// the block checks front entries for expiry, compares back entries, pushes
// the new sample, runs the emit test and sends each result beat, a result
// beat waiting while the output register is stalled. The steps are sequential
// because the deque memory has a single synchronous read port: each check of
// a stored entry needs one read. A new input beat is taken while the last
// result still waits in the output register.
module sliding_window_min_max_filter_top
	import swmm_pkg::*;
#(
	parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int MAX_COLUMN  = DEF_MAX_COLUMN
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// configuration write port
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,

	// sample input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          column_end,

	// result output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered_value,
	output logic                          column_done,
	output logic                          last_of_run
);

	// sizes derived from the parameters
	localparam int DEPTH = 2 * MAX_RADIUS + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(MAX_COLUMN);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int XW    = ((PW > RW + 1) ? PW : RW + 1) + 1;
	localparam int EW    = SAMPLE_BITS + PW;
	// conditional subtracts needed to reduce a radius modulo the column length
	localparam int NSUB  = MAX_RADIUS / MAX_COLUMN + 1;

	// ring pointer step with wrap at the deque depth
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

	// column counter step with wrap at the column length
	function automatic logic [PW-1:0] col_inc(input logic [PW-1:0] c);
		return (c == PW'(MAX_COLUMN - 1)) ? '0 : c + 1'b1;
	endfunction

	// radius modulo column length, NSUB compare-subtract steps
	function automatic logic [PW-1:0] rad_mod(input logic [RW-1:0] x);
		logic [RW-1:0] t;
		t = x;
		for (int i = 0; i < NSUB; i++) begin
			if (RW'(MAX_COLUMN) != '0 && 32'(t) >= MAX_COLUMN)
				t = t - RW'(MAX_COLUMN);
		end
		return PW'(t);
	endfunction

	// distance a - b modulo the column length
	function automatic logic [XW-1:0] col_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a >= b) ? XW'(a) - XW'(b) : XW'(a) + XW'(MAX_COLUMN) - XW'(b);
	endfunction

	// configuration registers
	logic [RADIUS_BITS-1:0] radius_q;
	logic                   find_min_q;
	logic                   cfg_hit;

	// per-beat latched input and radius
	logic signed [SAMPLE_BITS-1:0] s_q;
	logic                          end_q;
	logic [RW-1:0]                 r_q;
	logic [PW-1:0]                 rmod_q;
	logic [RW-1:0]                 r_clamp;

	// deque and column state
	swmm_state_t   state_q, state_d;
	logic          phase_q, phase_d;    // 0: expiry before push, 1: emitting
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [PW-1:0] colpos_q, colpos_d;
	logic [PW-1:0] emit_q, emit_d;

	// deque memory, entry = {value, position}
	logic [EW-1:0] mem [DEPTH];
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_q;
	logic          wr_en;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic                          out_done_q;
	logic                          out_last_q;
	logic                          out_free;
	logic                          out_load;

	// datapath terms
	logic signed [SAMPLE_BITS-1:0] rd_val;
	logic [PW-1:0]                 rd_pos;
	logic [XW-1:0]                 rel_diff, rel_sum, rel, two_r, r_x;
	logic [XW-1:0]                 pending, pend_m1;
	logic                          expired, dominated, more_now, more_after;
	logic [AW-1:0]                 head_inc, tail_m1;

	always_comb begin
		cfg_hit = cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_FIND_MIN);
		if (32'(radius_q) > MAX_RADIUS)
			r_clamp = RW'(MAX_RADIUS);
		else
			r_clamp = RW'(radius_q);
	end

	// memory read and write
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[tail_q] <= {s_q, colpos_q};
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		rd_val   = $signed(rd_q[EW-1:PW]);
		rd_pos   = rd_q[PW-1:0];
		r_x      = XW'(r_q);
		two_r    = XW'(r_q) << 1;
		// position of the read entry relative to the current window start
		rel_diff = col_diff(rd_pos, emit_q);
		rel_sum  = rel_diff + XW'(rmod_q);
		rel      = (rel_sum >= XW'(MAX_COLUMN)) ? rel_sum - XW'(MAX_COLUMN) : rel_sum;
		expired  = rel > two_r;
		// ties drop the older entry
		dominated = find_min_q ? (s_q <= rd_val) : (s_q >= rd_val);
		pending    = col_diff(colpos_q, emit_q);
		pend_m1    = pending - 1'b1;
		more_now   = (pending > r_x) || (end_q && pending != '0);
		more_after = (pend_m1 > r_x) || (end_q && pend_m1 != '0);
		head_inc   = ptr_inc(head_q);
		tail_m1    = ptr_dec(tail_q);
		out_free   = !out_valid_q || !out_stall;
	end

	// next state and datapath control
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		head_d   = head_q;
		tail_d   = tail_q;
		colpos_d = colpos_q;
		emit_d   = emit_q;
		rd_addr  = head_q;
		wr_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					phase_d = 1'b0;
					// front entry is read this cycle for the expiry check
					state_d = (head_q == tail_q) ? ST_PUSH : ST_EXP_CK;
				end
			end
			ST_EXP_CK: begin
				if (expired) begin
					head_d = head_inc;
					if (head_inc == tail_q)
						state_d = ST_PUSH;
					else
						rd_addr = head_inc;
				end else if (!phase_q) begin
					// front is live: move on to trimming the back
					rd_addr = tail_m1;
					state_d = ST_POP_CK;
				end else if (out_free) begin
					out_load = 1'b1;
					emit_d   = col_inc(emit_q);
					if (!more_after) begin
						state_d = ST_IDLE;
						if (end_q) begin
							head_d   = '0;
							tail_d   = '0;
							colpos_d = '0;
							emit_d   = '0;
						end
					end
				end
			end
			ST_POP_CK: begin
				if (dominated) begin
					tail_d = tail_m1;
					if (tail_m1 == head_q)
						state_d = ST_PUSH;
					else
						rd_addr = ptr_dec(tail_m1);
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				wr_en    = 1'b1;
				tail_d   = ptr_inc(tail_q);
				colpos_d = col_inc(colpos_q);
				state_d  = ST_EMIT_TEST;
			end
			ST_EMIT_TEST: begin
				if (more_now) begin
					phase_d = 1'b1;
					state_d = ST_EXP_CK;
				end else begin
					state_d = ST_IDLE;
					if (end_q) begin
						head_d   = '0;
						tail_d   = '0;
						colpos_d = '0;
						emit_d   = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			colpos_q   <= '0;
			emit_q     <= '0;
			radius_q   <= RADIUS_RESET;
			find_min_q <= FIND_MIN_RESET;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cfg_hit) begin
				// register write restarts the column
				head_q   <= '0;
				tail_q   <= '0;
				colpos_q <= '0;
				emit_q   <= '0;
				if (cfg_index == REG_RADIUS)
					radius_q <= cfg_data[RADIUS_BITS-1:0];
				else
					find_min_q <= cfg_data[0];
			end else begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				colpos_q <= colpos_d;
				emit_q   <= emit_d;
			end
		end
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			s_q    <= sample;
			end_q  <= column_end;
			r_q    <= r_clamp;
			rmod_q <= rad_mod(r_clamp);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= rd_val;
			out_done_q  <= end_q && (pending == XW'(1));
			out_last_q  <= !more_after;
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign filtered_value = out_value_q;
	assign column_done    = out_done_q;
	assign last_of_run    = out_last_q;

endmodule
